### hdl/mlpq_pkg.sv
// shared types and constants of the multilevel priority fifo
package mlpq_pkg;

  // default configuration
  localparam int DEF_LOWEST_LEVEL = 1;
  localparam int DEF_LEVELS       = 8;
  localparam int DEF_LEVEL_DEPTH  = 16;
  localparam int DEF_TAG_BITS     = 16;

  // field widths of the request and result
  localparam int PRIO_W = 4;
  localparam int TAG_W  = 16;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic {
    S_IDLE,
    S_POP
  } fsm_state_t;

  // one request
  typedef struct packed {
    logic              command;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  tag;
  } req_t;

  // one result
  typedef struct packed {
    status_t           status;
    logic [TAG_W-1:0]  popped_tag;
    logic [PRIO_W-1:0] popped_level;
    logic              not_empty;
  } result_t;

  // pointer update for one level
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [PRIO_W-1:0] level;
  } lvl_op_t;

endpackage

### hdl/mlpq_level_ctl.sv
// per-level head, tail and count registers with top level search
module mlpq_level_ctl
  import mlpq_pkg::*;
#(
  parameter int LEVELS      = DEF_LEVELS,
  parameter int LEVEL_DEPTH = DEF_LEVEL_DEPTH,
  localparam int LVL_W  = $clog2(LEVELS),
  localparam int SLOT_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1,
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  lvl_op_t           op,
  output logic [LEVELS-1:0] occupied,
  output logic [LVL_W-1:0]  top_level,
  output logic              full,
  output logic [SLOT_W-1:0] head_slot,
  output logic [SLOT_W-1:0] tail_slot
);

  logic [SLOT_W-1:0] head  [LEVELS];
  logic [SLOT_W-1:0] tail  [LEVELS];
  logic [CNT_W-1:0]  count [LEVELS];
  logic [LVL_W-1:0]  sel;

  assign sel = op.level[LVL_W-1:0];

  // pointers and fill of the addressed level
  assign head_slot = head[sel];
  assign tail_slot = tail[sel];
  assign full      = (count[sel] == CNT_W'(LEVEL_DEPTH));

  // per-level occupancy and highest occupied level
  always_comb begin
    top_level = '0;
    for (int i = 0; i < LEVELS; i++) begin
      occupied[i] = (count[i] != '0);
      if (occupied[i]) begin
        top_level = LVL_W'(i);
      end
    end
  end

  // wrap a slot index at the fifo depth
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
    next_slot = (slot == SLOT_W'(LEVEL_DEPTH - 1)) ? '0 : slot + 1'b1;
  endfunction

  // pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else if (op.push) begin
      tail[sel]  <= next_slot(tail[sel]);
      count[sel] <= count[sel] + 1'b1;
    end else if (op.pop) begin
      head[sel]  <= next_slot(head[sel]);
      count[sel] <= count[sel] - 1'b1;
    end
  end

endmodule

### hdl/multilevel_priority_fifo_core.sv
// multilevel priority fifo: one fifo per level in a shared entry memory
// insert: result strobe in the next cycle, busy stays low, one insert per cycle unless busy
// pop of a queued entry: entry memory read is registered, busy is high one cycle and blocks
//   requests, result strobe follows the read; empty pop answers like an insert
// results are strobed for one cycle and cannot be stalled
// synchronous reset empties every level at once; the entry memory is not cleared
module multilevel_priority_fifo_core
  import mlpq_pkg::*;
#(
  parameter int LOWEST_LEVEL = DEF_LOWEST_LEVEL,
  parameter int LEVELS       = DEF_LEVELS,
  parameter int LEVEL_DEPTH  = DEF_LEVEL_DEPTH,
  parameter int TAG_BITS     = DEF_TAG_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  req_t    req,
  output logic    done,
  output result_t result
);

  localparam int LVL_W     = $clog2(LEVELS);
  localparam int SLOT_W    = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int MEM_DEPTH = LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  fsm_state_t         state, state_next;
  logic               accept;
  logic               is_pop;
  logic               in_range;
  logic [LVL_W-1:0]   ins_lv;
  logic [LVL_W-1:0]   top_level;
  logic [LEVELS-1:0]  occupied;
  logic               any_queued;
  logic               full;
  logic [SLOT_W-1:0]  head_slot;
  logic [SLOT_W-1:0]  tail_slot;
  logic [LVL_W-1:0]   op_lv;
  lvl_op_t            op;
  logic               do_push;
  logic               do_pop;
  logic [ADDR_W-1:0]  lv_base;
  logic [ADDR_W-1:0]  mem_addr;
  logic [TAG_BITS-1:0] mem [MEM_DEPTH];
  logic [TAG_BITS-1:0] rd_data;
  logic [PRIO_W-1:0]  pop_level, pop_level_next;
  logic               done_next;
  result_t            result_next;

  // request decode
  assign accept   = start && !busy;
  assign is_pop   = (req.command == CMD_POP);
  assign in_range = (6'(req.priority_req) >= 6'(LOWEST_LEVEL)) &&
                    (6'(req.priority_req) <  6'(LOWEST_LEVEL + LEVELS));
  assign ins_lv   = LVL_W'(req.priority_req - PRIO_W'(LOWEST_LEVEL));
  assign any_queued = |occupied;

  // level pointer control
  assign op_lv      = is_pop ? top_level : ins_lv;
  assign do_push    = accept && !is_pop && in_range && !full;
  assign do_pop     = accept && is_pop && any_queued;
  assign op         = '{push: do_push, pop: do_pop, level: PRIO_W'(op_lv)};

  mlpq_level_ctl #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_level_ctl (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .occupied  (occupied),
    .top_level (top_level),
    .full      (full),
    .head_slot (head_slot),
    .tail_slot (tail_slot)
  );

  // entry address: level base plus slot
  assign lv_base  = ADDR_W'(ADDR_W'(op_lv) * ADDR_W'(LEVEL_DEPTH));
  assign mem_addr = lv_base + ADDR_W'(is_pop ? head_slot : tail_slot);

  // entry memory, one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[mem_addr] <= TAG_BITS'(req.tag);
    end
    if (do_pop) begin
      rd_data <= mem[mem_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (do_pop) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and result assembly
  always_comb begin
    busy           = 1'b0;
    done_next      = 1'b0;
    result_next    = '0;
    pop_level_next = pop_level;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          done_next = !do_pop;
          if (is_pop) begin
            pop_level_next = PRIO_W'(top_level) + PRIO_W'(LOWEST_LEVEL);
            result_next.status = ST_EMPTY;
          end else if (!in_range) begin
            result_next.status    = ST_RANGE;
            result_next.not_empty = any_queued;
          end else if (full) begin
            result_next.status    = ST_FULL;
            result_next.not_empty = any_queued;
          end else begin
            result_next.status    = ST_OK;
            result_next.not_empty = 1'b1;
          end
        end
      end
      S_POP: begin
        busy                     = 1'b1;
        done_next                = 1'b1;
        result_next.status       = ST_OK;
        result_next.popped_tag   = TAG_W'(rd_data);
        result_next.popped_level = pop_level;
        result_next.not_empty    = any_queued;
      end
      default: busy = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result    <= result_next;
    pop_level <= pop_level_next;
  end

endmodule

### hdl/mlpq_checker.sv
// port-level checker of the multilevel priority fifo and its bind
module mlpq_checker
  import mlpq_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input req_t    req,
  input logic    done,
  input result_t result
);

  // an insert request answers in the very next cycle
  a_insert_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.command == CMD_INSERT |=> done && !busy)
    else $error("insert request did not answer in the next cycle");

  // a pop request either answers at once (empty) or holds busy for its read
  a_pop_path: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.command == CMD_POP |=> (done ^ busy))
    else $error("pop request neither answered nor went busy");

  // busy lasts exactly one cycle and ends in a successful pop result
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done && result.status == ST_OK)
    else $error("pop read did not finish with an ok result");

  // an empty result carries no entry and reports an empty queue
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_EMPTY |->
      result.popped_tag == '0 && result.popped_level == '0 && !result.not_empty)
    else $error("empty result carries data or a queued flag");

  // a result strobe never coincides with busy
  a_no_back_busy: assert property (@(posedge clk) disable iff (rst)
    done && busy |-> 1'b0)
    else $error("result strobe while a pop read is pending");

endmodule

bind multilevel_priority_fifo_core mlpq_checker u_mlpq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .req    (req),
  .done   (done),
  .result (result)
);
